// ===== rtl/ecrp_pkg.sv =====
`default_nettype none
package ecrp_pkg;

  localparam int DataW = 16;
  localparam int AddrW = 24;
  localparam int EvW   = 5;

  // action codes
  localparam logic [2:0] ACT_READ  = 3'd0;
  localparam logic [2:0] ACT_WRITE = 3'd1;
  localparam logic [2:0] ACT_TICK  = 3'd2;
  localparam logic [2:0] ACT_INIT  = 3'd3;
  localparam logic [2:0] ACT_EVENT = 3'd4;

  // bus ports
  localparam logic PORT_RDP = 1'b0;
  localparam logic PORT_RAP = 1'b1;

  // register pointer values
  localparam logic [DataW-1:0] SEL_CSR0 = 16'd0;
  localparam logic [DataW-1:0] SEL_CSR1 = 16'd1;
  localparam logic [DataW-1:0] SEL_CSR2 = 16'd2;
  localparam logic [DataW-1:0] SEL_CSR3 = 16'd3;

  // csr0 bits
  localparam logic [DataW-1:0] B_ESUM = 16'h8000;
  localparam logic [DataW-1:0] B_BABL = 16'h4000;
  localparam logic [DataW-1:0] B_MISS = 16'h1000;
  localparam logic [DataW-1:0] B_MERR = 16'h0800;
  localparam logic [DataW-1:0] B_RINT = 16'h0400;
  localparam logic [DataW-1:0] B_TINT = 16'h0200;
  localparam logic [DataW-1:0] B_IDON = 16'h0100;
  localparam logic [DataW-1:0] B_INTR = 16'h0080;
  localparam logic [DataW-1:0] B_INEA = 16'h0040;
  localparam logic [DataW-1:0] B_RXON = 16'h0020;
  localparam logic [DataW-1:0] B_TXON = 16'h0010;
  localparam logic [DataW-1:0] B_TDMD = 16'h0008;
  localparam logic [DataW-1:0] B_STOP = 16'h0004;
  localparam logic [DataW-1:0] B_STRT = 16'h0002;
  localparam logic [DataW-1:0] B_INIT = 16'h0001;

  localparam logic [DataW-1:0] M_ERRS  = 16'h7800;
  localparam logic [DataW-1:0] M_W1C   = 16'h7F00;
  localparam logic [DataW-1:0] M_CAUSE = 16'h5F00;
  localparam logic [DataW-1:0] M_ADDRL = 16'hFFFE;

  localparam int MB_RX_OFF = 0;
  localparam int MB_TX_OFF = 1;

  typedef struct packed {
    logic [2:0]       action;
    logic             port;
    logic [DataW-1:0] wdata;
    logic [DataW-1:0] mode_word;
    logic             init_error;
    logic [EvW-1:0]   event_bits;
  } in_item_t;

  typedef struct packed {
    logic [DataW-1:0] rdata;
    logic             irq;
    logic             init_request;
    logic [AddrW-1:0] init_address;
    logic             tx_poll;
    logic             rx_poll;
  } out_item_t;

endpackage
`default_nettype wire

// ===== rtl/ecrp_csr.sv =====
`default_nettype none
module ecrp_csr
  import ecrp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire in_item_t  item,
  output out_item_t      res
);

  logic [DataW-1:0] csr0_r, csr0_nxt;
  logic [DataW-1:0] csr1_r, csr1_nxt;
  logic [DataW-1:0] csr2_r, csr2_nxt;
  logic [DataW-1:0] csr3_r, csr3_nxt;
  logic [DataW-1:0] rap_r, rap_nxt;
  logic [DataW-1:0] mode_r, mode_nxt;
  logic             armed_r, armed_nxt;

  always_comb begin
    logic [DataW-1:0] c;
    logic [DataW-1:0] s;
    c         = csr0_r;
    s         = '0;
    csr1_nxt  = csr1_r;
    csr2_nxt  = csr2_r;
    csr3_nxt  = csr3_r;
    rap_nxt   = rap_r;
    mode_nxt  = mode_r;
    armed_nxt = armed_r;
    res       = '0;
    case (item.action)
      ACT_READ: begin
        if (item.port == PORT_RAP) begin
          res.rdata = rap_r;
        end else begin
          unique case (rap_r)
            SEL_CSR0: res.rdata = csr0_r | ((|(csr0_r & M_ERRS)) ? B_ESUM : '0);
            SEL_CSR1: res.rdata = csr1_r;
            SEL_CSR2: res.rdata = csr2_r;
            SEL_CSR3: res.rdata = csr3_r;
            default:  res.rdata = '0;
          endcase
        end
      end
      ACT_WRITE: begin
        if (item.port == PORT_RAP) begin
          rap_nxt = item.wdata;
        end else begin
          unique case (rap_r)
            SEL_CSR0: begin
              c = (csr0_r & ~B_INEA) | (item.wdata & B_INEA);
              c = c & ~(item.wdata & M_W1C);
              if (|(item.wdata & B_STOP)) begin
                c = c | B_STOP;
                c = c & ~(B_STRT | B_INIT | B_IDON | B_TXON | B_RXON);
                c = c & ~(M_ERRS | B_ESUM);
                armed_nxt = 1'b0;
              end else if (|(item.wdata & B_INIT) && !(|(c & B_INIT))) begin
                armed_nxt = 1'b0;
                res.init_request = 1'b1;
                res.init_address = {csr2_r[7:0], csr1_r & M_ADDRL};
              end else if (|(item.wdata & B_STRT) && !(|(c & B_STRT))) begin
                c = (c | B_STRT) & ~B_STOP;
                if (!mode_r[MB_RX_OFF]) c = c | B_RXON;
                if (!mode_r[MB_TX_OFF]) c = c | B_TXON;
                armed_nxt = 1'b1;
              end else if (|(item.wdata & B_TDMD)) begin
                res.tx_poll = 1'b1;
              end
              c = (|(c & M_CAUSE)) ? (c | B_INTR) : (c & ~B_INTR);
            end
            SEL_CSR1: csr1_nxt = item.wdata;
            SEL_CSR2: csr2_nxt = item.wdata;
            SEL_CSR3: csr3_nxt = item.wdata;
            default: ;
          endcase
        end
      end
      ACT_TICK: begin
        if (armed_r) begin
          if ((csr0_r & (B_STRT | B_INIT)) == B_INIT) begin
            c = csr0_r | B_IDON | B_INTR;
            armed_nxt = 1'b0;
          end else begin
            res.rx_poll = !mode_r[MB_RX_OFF];
            res.tx_poll = !mode_r[MB_TX_OFF];
          end
        end
      end
      ACT_INIT: begin
        if (item.init_error) begin
          c = (csr0_r | B_MERR | B_IDON | B_INTR) & ~(B_RXON | B_TXON);
        end else begin
          mode_nxt  = item.mode_word;
          c         = (csr0_r | B_INIT) & ~B_STOP;
          armed_nxt = 1'b1;
        end
        c = (|(c & M_CAUSE)) ? (c | B_INTR) : (c & ~B_INTR);
      end
      ACT_EVENT: begin
        if (item.event_bits[0]) s = s | B_RINT;
        if (item.event_bits[1]) s = s | B_TINT;
        if (item.event_bits[2]) s = s | B_MERR;
        if (item.event_bits[3]) s = s | B_MISS;
        if (item.event_bits[4]) s = s | B_BABL;
        c = csr0_r | s;
        c = (|(c & M_CAUSE)) ? (c | B_INTR) : (c & ~B_INTR);
      end
      default: ;
    endcase
    csr0_nxt = c;
    res.irq  = (|(c & B_INTR)) && (|(c & B_INEA));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      csr0_r  <= '0;
      csr1_r  <= '0;
      csr2_r  <= '0;
      csr3_r  <= '0;
      rap_r   <= '0;
      mode_r  <= '0;
      armed_r <= 1'b0;
    end else if (en) begin
      csr0_r  <= csr0_nxt;
      csr1_r  <= csr1_nxt;
      csr2_r  <= csr2_nxt;
      csr3_r  <= csr3_nxt;
      rap_r   <= rap_nxt;
      mode_r  <= mode_nxt;
      armed_r <= armed_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ethernet_controller_register_port.sv =====
// channel  ports                          beat
// input    in_valid  in_stall  in_data    one bus access, tick, init load or status event
// output   out_valid out_stall out_data   read data, irq level and fetch/poll requests
//
// one beat per cycle sustained while out_stall is low; a beat lands in the input
// register, is processed against the csr state combinationally and the result is
// held in the output register, which drives output valid
// rst_n is synchronous, active low, and clears all csr state and both valids
// out_stall holds the output register; the input register then fills and in_stall rises
`default_nettype none
module ethernet_controller_register_port
  import ecrp_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      in_vld_r, in_vld_nxt;
  in_item_t  in_data_r;
  logic      out_vld_r, out_vld_nxt;
  out_item_t out_data_r;
  out_item_t res;
  logic      adv;
  logic      take;

  assign adv      = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = in_vld_r && !adv;
  assign take     = in_valid && !in_stall;

  assign in_vld_nxt  = take || (in_vld_r && !adv);
  assign out_vld_nxt = adv || (out_vld_r && out_stall);

  ecrp_csr u_csr (
    .clk  (clk),
    .rst_n(rst_n),
    .en   (adv),
    .item (in_data_r),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_data_r <= in_data;
    end
    if (adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ===== dv/ethernet_controller_register_port_tb.sv =====
`timescale 1ns / 100ps
module ethernet_controller_register_port_tb;
  import ecrp_pkg::*;

  localparam logic [2:0] ACT_SPARE = 3'd5;
  localparam logic [2:0] ACT_LAST  = 3'd7;
  localparam int RAND_BEATS = 1700;

  logic      clk;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  ethernet_controller_register_port DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("** ethernet_controller_register_port: FAILED **");
    $finish;
  end

  // register state mirror
  logic [15:0] m_csr0, m_csr1, m_csr2, m_csr3, m_rap, m_mode;
  bit          m_armed;

  out_item_t result_q[$];
  int        in_idle_pct, out_idle_pct;
  int        n_err, n_sent, n_checked, n_fetch, n_poll, n_irq;

  typedef struct {
    in_item_t  stim;
    bit        typed;
    out_item_t want;
  } script_row_t;
  script_row_t script_q[$];

  function automatic logic [15:0] intr_fix(logic [15:0] c);
    if ((c & M_CAUSE) != '0) return c | B_INTR;
    return c & ~B_INTR;
  endfunction

  function automatic out_item_t csr_step(in_item_t it);
    out_item_t   r;
    logic [15:0] c;
    logic [15:0] s;
    r = '0;
    case (it.action)
      ACT_READ: begin
        if (it.port == PORT_RAP) r.rdata = m_rap;
        else begin
          case (m_rap)
            SEL_CSR0: r.rdata = m_csr0 | (((m_csr0 & M_ERRS) != '0) ? B_ESUM : 16'h0);
            SEL_CSR1: r.rdata = m_csr1;
            SEL_CSR2: r.rdata = m_csr2;
            SEL_CSR3: r.rdata = m_csr3;
            default:  r.rdata = '0;
          endcase
        end
      end
      ACT_WRITE: begin
        if (it.port == PORT_RAP) m_rap = it.wdata;
        else if (m_rap == SEL_CSR0) begin
          c = (m_csr0 & ~B_INEA) | (it.wdata & B_INEA);
          c = c & ~(it.wdata & M_W1C);
          if ((it.wdata & B_STOP) != '0) begin
            c = c | B_STOP;
            c = c & ~(B_STRT | B_INIT | B_IDON | B_TXON | B_RXON | M_ERRS | B_ESUM);
            m_armed = 1'b0;
          end else if ((it.wdata & B_INIT) != '0 && (c & B_INIT) == '0) begin
            m_armed = 1'b0;
            r.init_request = 1'b1;
            r.init_address = {m_csr2[7:0], m_csr1 & M_ADDRL};
          end else if ((it.wdata & B_STRT) != '0 && (c & B_STRT) == '0) begin
            c = (c | B_STRT) & ~B_STOP;
            if (!m_mode[MB_RX_OFF]) c = c | B_RXON;
            if (!m_mode[MB_TX_OFF]) c = c | B_TXON;
            m_armed = 1'b1;
          end else if ((it.wdata & B_TDMD) != '0) begin
            r.tx_poll = 1'b1;
          end
          m_csr0 = intr_fix(c);
        end else if (m_rap == SEL_CSR1) m_csr1 = it.wdata;
        else if (m_rap == SEL_CSR2) m_csr2 = it.wdata;
        else if (m_rap == SEL_CSR3) m_csr3 = it.wdata;
      end
      ACT_TICK: begin
        if (m_armed) begin
          if ((m_csr0 & (B_STRT | B_INIT)) == B_INIT) begin
            m_csr0 = m_csr0 | B_IDON | B_INTR;
            m_armed = 1'b0;
          end else begin
            r.rx_poll = !m_mode[MB_RX_OFF];
            r.tx_poll = !m_mode[MB_TX_OFF];
          end
        end
      end
      ACT_INIT: begin
        if (it.init_error) begin
          m_csr0 = (m_csr0 | B_MERR | B_IDON | B_INTR) & ~(B_RXON | B_TXON);
        end else begin
          m_mode = it.mode_word;
          m_csr0 = (m_csr0 | B_INIT) & ~B_STOP;
          m_armed = 1'b1;
        end
        m_csr0 = intr_fix(m_csr0);
      end
      ACT_EVENT: begin
        s = '0;
        if (it.event_bits[0]) s = s | B_RINT;
        if (it.event_bits[1]) s = s | B_TINT;
        if (it.event_bits[2]) s = s | B_MERR;
        if (it.event_bits[3]) s = s | B_MISS;
        if (it.event_bits[4]) s = s | B_BABL;
        m_csr0 = intr_fix(m_csr0 | s);
      end
      default: ;
    endcase
    r.irq = ((m_csr0 & B_INTR) != '0) && ((m_csr0 & B_INEA) != '0);
    return r;
  endfunction

  function automatic in_item_t item(logic [2:0] a, logic p, logic [15:0] w,
                                    logic [15:0] m = '0, logic e = 1'b0,
                                    logic [4:0] ev = '0);
    in_item_t it;
    it.action = a;
    it.port = p;
    it.wdata = w;
    it.mode_word = m;
    it.init_error = e;
    it.event_bits = ev;
    return it;
  endfunction

  function automatic out_item_t res(logic [15:0] rd, logic irq = 1'b0, logic req = 1'b0,
                                    logic [23:0] addr = '0);
    out_item_t r;
    r = '0;
    r.rdata = rd;
    r.irq = irq;
    r.init_request = req;
    r.init_address = addr;
    return r;
  endfunction

  task automatic row(in_item_t s, bit typed = 1'b0, out_item_t w = '0);
    script_row_t sr;
    sr.stim = s;
    sr.typed = typed;
    sr.want = w;
    script_q.push_back(sr);
  endtask

  // drive one beat, predict once it is taken
  task automatic send(in_item_t it, bit typed = 1'b0, out_item_t want = '0);
    out_item_t r;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = csr_step(it);
    result_q.push_back(typed ? want : r);
    n_sent++;
  endtask

  function automatic in_item_t rand_item();
    in_item_t it;
    int k;
    it.port = 1'($urandom);
    it.wdata = 16'($urandom);
    it.mode_word = 16'($urandom);
    it.init_error = ($urandom_range(7) == 0);
    it.event_bits = 5'($urandom);
    k = $urandom_range(99);
    if (k < 25) begin
      it.action = ACT_READ;
      it.port = ($urandom_range(4) == 0) ? PORT_RAP : PORT_RDP;
    end else if (k < 55) begin
      it.action = ACT_WRITE;
      if ($urandom_range(3) == 0) begin
        it.port = PORT_RAP;
        if ($urandom_range(9) != 0) it.wdata = 16'($urandom_range(3));
      end else begin
        it.port = PORT_RDP;
        if (m_rap == SEL_CSR0) begin
          if ($urandom_range(9) != 0) it.wdata = it.wdata & ~B_STOP;
          if ($urandom_range(3) != 0) it.wdata = it.wdata & ~B_INIT;
          if ($urandom_range(3) != 0) it.wdata = it.wdata | B_INEA;
        end
      end
    end else if (k < 75) it.action = ACT_TICK;
    else if (k < 85) it.action = ACT_INIT;
    else if (k < 95) it.action = ACT_EVENT;
    else it.action = 3'($urandom_range(ACT_SPARE, ACT_LAST));
    return it;
  endfunction

  // address setup, init fetch, load, idon tick, start, then some traffic
  task automatic bring_up();
    int n;
    send(item(ACT_WRITE, PORT_RAP, SEL_CSR1));
    send(item(ACT_WRITE, PORT_RDP, 16'($urandom)));
    send(item(ACT_WRITE, PORT_RAP, SEL_CSR2));
    send(item(ACT_WRITE, PORT_RDP, 16'($urandom)));
    send(item(ACT_WRITE, PORT_RAP, SEL_CSR0));
    send(item(ACT_WRITE, PORT_RDP, B_INIT | (($urandom_range(3) != 0) ? B_INEA : 16'h0)));
    send(item(ACT_INIT, PORT_RDP, '0, 16'($urandom), ($urandom_range(7) == 0)));
    send(item(ACT_TICK, PORT_RDP, '0));
    send(item(ACT_WRITE, PORT_RDP, B_INEA | B_IDON | B_STRT));
    n = $urandom_range(3, 8);
    repeat (n) send(rand_item());
  endtask

  function automatic void cmp(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
      n_err++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t w;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          $display("%0t unexpected beat: expected none, actual %h", $time, out_data);
          n_err++;
        end else begin
          w = result_q.pop_front();
          cmp("rdata", 32'(w.rdata), 32'(out_data.rdata));
          cmp("irq", 32'(w.irq), 32'(out_data.irq));
          cmp("init_request", 32'(w.init_request), 32'(out_data.init_request));
          cmp("init_address", 32'(w.init_address), 32'(out_data.init_address));
          cmp("tx_poll", 32'(w.tx_poll), 32'(out_data.tx_poll));
          cmp("rx_poll", 32'(w.rx_poll), 32'(out_data.rx_poll));
          n_checked++;
          if (w.init_request) n_fetch++;
          if (w.tx_poll || w.rx_poll) n_poll++;
          if (w.irq) n_irq++;
        end
      end
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  initial begin : main
    int ph;
    int target;
    int guard;
    m_csr0 = '0; m_csr1 = '0; m_csr2 = '0; m_csr3 = '0; m_rap = '0; m_mode = '0;
    m_armed = 1'b0;
    in_idle_pct = 0;
    out_idle_pct = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    row(item(ACT_READ, PORT_RDP, '0), 1'b1, res(16'h0000));
    row(item(ACT_READ, PORT_RAP, '0), 1'b1, res(16'h0000));
    row(item(ACT_WRITE, PORT_RAP, 16'hFFFF), 1'b1, res(16'h0000));
    row(item(ACT_READ, PORT_RAP, '0), 1'b1, res(16'hFFFF));
    row(item(ACT_READ, PORT_RDP, '0), 1'b1, res(16'h0000));
    row(item(ACT_WRITE, PORT_RDP, 16'hFFFF), 1'b1, res(16'h0000));
    row(item(ACT_WRITE, PORT_RAP, SEL_CSR3));
    row(item(ACT_WRITE, PORT_RDP, 16'hFFFF));
    row(item(ACT_READ, PORT_RDP, '0), 1'b1, res(16'hFFFF));
    row(item(ACT_WRITE, PORT_RAP, SEL_CSR1));
    row(item(ACT_WRITE, PORT_RDP, 16'hFFFF));
    row(item(ACT_WRITE, PORT_RAP, SEL_CSR2));
    row(item(ACT_WRITE, PORT_RDP, 16'hFFFF));
    row(item(ACT_WRITE, PORT_RAP, SEL_CSR0));
    row(item(ACT_WRITE, PORT_RDP, B_INIT), 1'b1, res(16'h0000, 1'b0, 1'b1, 24'hFFFFFE));
    row(item(ACT_TICK, PORT_RDP, '0));
    row(item(ACT_INIT, PORT_RDP, 16'hFFFF, 16'hFFFF, 1'b1));
    row(item(ACT_WRITE, PORT_RDP, B_INEA | M_W1C));
    row(item(ACT_INIT, PORT_RDP, '0, 16'h0000, 1'b0));
    row(item(ACT_TICK, PORT_RDP, '0));
    row(item(ACT_WRITE, PORT_RDP, B_INEA | B_IDON | B_STRT));
    row(item(ACT_TICK, PORT_RDP, '0));
    row(item(ACT_WRITE, PORT_RDP, B_INEA | B_TDMD));
    row(item(ACT_EVENT, PORT_RDP, '0, '0, 1'b0, 5'h1F));
    row(item(ACT_READ, PORT_RDP, '0));
    row(item(ACT_WRITE, PORT_RDP, B_INEA | B_STOP));
    row(item(ACT_SPARE, PORT_RAP, 16'hFFFF, 16'hFFFF, 1'b1, 5'h1F));
    row(item(ACT_LAST, PORT_RDP, '0));

    foreach (script_q[i]) send(script_q[i].stim, script_q[i].typed, script_q[i].want);

    for (ph = 0; ph < 3; ph++) begin
      in_idle_pct  = (ph == 0) ? 18 : (ph == 1) ? 52 : 0;
      out_idle_pct = (ph == 0) ? 52 : (ph == 1) ? 18 : 0;
      target = n_sent + RAND_BEATS / 3;
      while (n_sent < target) begin
        if ($urandom_range(9) < 4) bring_up();
        else send(rand_item());
      end
      // let the pipe drain before the next phase
      in_valid <= 1'b0;
      @(posedge clk);
      while (result_q.size() != 0) @(posedge clk);
    end

    in_valid <= 1'b0;
    for (guard = 0; guard < 5000 && result_q.size() != 0; guard++) @(posedge clk);
    repeat (10) @(posedge clk);
    if (result_q.size() != 0) begin
      $display("%0t %0d beats never arrived", $time, result_q.size());
      n_err++;
    end
    $display("%0d beats sent, %0d results checked; %0d init fetches, %0d poll requests,",
             n_sent, n_checked, n_fetch, n_poll);
    $display("%0d results with irq high, over three idle/stall mixes", n_irq);
    if (n_err == 0) begin
      $display("** ethernet_controller_register_port: PASSED **");
    end else begin
      $display("** ethernet_controller_register_port: FAILED **");
    end
    $finish;
  end

endmodule
